// ----- rtl/dsfl_pkg.sv -----
package dsfl_pkg;

    // fixed field widths
    localparam int ADDR_W    = 64;
    localparam int SIZE_W    = 13;
    localparam int COUNT_W   = 11;
    localparam int INDEX_W   = 10;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    // offset that can still map to a slot: count times stride fits here
    localparam int OFS_W  = COUNT_W + SIZE_W;
    localparam int STEP_W = $clog2(OFS_W);

    // iteration counts of the shared unit
    localparam int MUL_STEPS = SIZE_W;
    localparam int DIV_STEPS = OFS_W;

    // request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    // register reset values
    localparam logic [SIZE_W-1:0]  SIZE_RST  = 13'd32;
    localparam logic [COUNT_W-1:0] COUNT_RST = 11'd1024;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SUB,
        S_DIV,
        S_MUL,
        S_ADD,
        S_DONE
    } seq_state_t;

    typedef enum logic {
        AR_MUL,
        AR_DIV
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

endpackage

// ----- rtl/dsfl_link_ram.sv -----
module dsfl_link_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 11
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/dsfl_arith.sv -----
module dsfl_arith (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dsfl_pkg::arith_req_t         req,
    input  logic [dsfl_pkg::OFS_W-1:0]   opa,
    input  logic [dsfl_pkg::SIZE_W-1:0]  opb,
    output logic                         done,
    output logic [dsfl_pkg::OFS_W-1:0]   result
);

    import dsfl_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    arith_op_t           op_reg, op_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [OFS_W-1:0]    acc_reg, acc_next;
    logic [OFS_W-1:0]    mcand_reg, mcand_next;
    logic [SIZE_W-1:0]   opb_reg, opb_next;
    logic [SIZE_W-1:0]   rem_reg, rem_next;

    // the one adder: a + b or a - b, carry out is no-borrow on subtract
    logic [OFS_W-1:0]    add_a, add_b;
    logic                add_sub;
    logic [OFS_W:0]      add_sum;
    logic [SIZE_W:0]     rem_sh;
    logic [STEP_W-1:0]   last_step;

    assign add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                   + (OFS_W+1)'(add_sub);
    assign rem_sh  = {rem_reg, acc_reg[OFS_W-1]};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        opb_next   = opb_reg;
        rem_next   = rem_reg;
        add_a      = {acc_reg[OFS_W-2:0], 1'b0};
        add_b      = '0;
        add_sub    = 1'b0;
        last_step  = (op_reg == AR_MUL) ? STEP_W'(MUL_STEPS - 1) : STEP_W'(DIV_STEPS - 1);

        if (req.start)
        begin
            busy_next  = 1'b1;
            op_next    = req.op;
            cnt_next   = '0;
            opb_next   = opb;
            mcand_next = opa;
            rem_next   = '0;
            acc_next   = (req.op == AR_MUL) ? '0 : opa;
        end
        else if (busy_reg)
        begin
            if (op_reg == AR_MUL)
            begin
                // msb first shift and add
                add_a    = {acc_reg[OFS_W-2:0], 1'b0};
                add_b    = opb_reg[SIZE_W-1] ? mcand_reg : '0;
                add_sub  = 1'b0;
                acc_next = add_sum[OFS_W-1:0];
                opb_next = {opb_reg[SIZE_W-2:0], 1'b0};
            end
            else
            begin
                // restoring division, one quotient bit a step
                add_a    = OFS_W'(rem_sh);
                add_b    = OFS_W'(opb_reg);
                add_sub  = 1'b1;
                rem_next = add_sum[OFS_W] ? add_sum[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
                acc_next = {acc_reg[OFS_W-2:0], add_sum[OFS_W]};
            end
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= AR_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        opb_reg   <= opb_next;
        rem_reg   <= rem_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

// ----- rtl/descriptor_slot_free_list_top.sv -----
// descriptor slot allocator over a free list of equal-sized slots
// request channel: in_valid/in_ready with req_type and free_addr; an allocate
//   request pops the head slot, a free request maps an address to a slot
//   index and pushes it on the head
// result channel: out_valid/out_ready with status, slot_index, slot_addr; one
//   result per request, held in an output register until taken
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always
//   ready; 0 base address, 1 slot size, 2 slot count (written while idle)
// sequencing: one request at a time; an allocate runs the 13-step shift-add
//   multiply and a free that reaches the divide runs the 24-step restoring
//   divide, both on the shared add/subtract unit; an allocate on an empty
//   list and a free below base or far past the region skip the unit
// reset: the link table is rebuilt by a clearing pass over all MAX_SLOTS
//   entries, entry i pointing at i+1; in_ready stays low during it, config
//   writes are taken; head returns to slot zero
// stall: a finished result waits in the output register; the next request is
//   accepted meanwhile, and a second result waits in the sequencer until the
//   output register frees up
module descriptor_slot_free_list_top #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            req_type,
    input  logic [dsfl_pkg::ADDR_W-1:0]     free_addr,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [dsfl_pkg::STATUS_W-1:0]   status,
    output logic [dsfl_pkg::INDEX_W-1:0]    slot_index,
    output logic [dsfl_pkg::ADDR_W-1:0]     slot_addr,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dsfl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dsfl_pkg::ADDR_W-1:0]     cfg_data
);

    import dsfl_pkg::*;

    // link entries hold 0..MAX_SLOTS, MAX_SLOTS being the end of the list
    localparam int LW    = $clog2(MAX_SLOTS + 1);
    localparam int IW    = $clog2(MAX_SLOTS);
    localparam int CMP_W = (LW > COUNT_W) ? LW : COUNT_W;

    seq_state_t          state_reg, state_next;

    // config registers
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    // list state
    logic [LW-1:0]       head_reg, head_next;
    logic [IW-1:0]       clr_cnt_reg, clr_cnt_next;

    // request and result holding
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [INDEX_W-1:0]  res_index_reg, res_index_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [INDEX_W-1:0]  out_index_reg, out_index_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;

    // link table port
    logic                ram_we, ram_re;
    logic [IW-1:0]       ram_waddr, ram_raddr;
    logic [LW-1:0]       ram_wdata, ram_rdata;

    // shared unit
    arith_req_t          ar_req;
    logic [OFS_W-1:0]    ar_opa, ar_result;
    logic                ar_done;

    // wide add/subtract for offset and final address
    logic [ADDR_W-1:0]   wide_a, wide_b;
    logic                wide_sub;
    logic [ADDR_W:0]     wide_sum;

    logic [CMP_W-1:0]    cap;
    logic [SIZE_W-1:0]   stride;
    logic                list_empty;
    logic                in_fire;
    logic                out_free;
    logic [OFS_W-1:0]    head_wide;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    // capacity is min(slot_count, MAX_SLOTS); a zero size strides by one
    assign cap = (CMP_W'(count_reg) < CMP_W'(MAX_SLOTS)) ? CMP_W'(count_reg)
                                                         : CMP_W'(MAX_SLOTS);
    assign stride     = (size_reg == '0) ? SIZE_W'(1) : size_reg;
    assign list_empty = (CMP_W'(head_reg) >= cap);
    assign head_wide  = OFS_W'(head_reg);

    assign wide_sum = {1'b0, wide_a} + {1'b0, (wide_sub ? ~wide_b : wide_b)}
                    + (ADDR_W+1)'(wide_sub);

    dsfl_link_ram #(
        .DEPTH (MAX_SLOTS),
        .AW    (IW),
        .DW    (LW)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dsfl_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (ar_req),
        .opa    (ar_opa),
        .opb    (stride),
        .done   (ar_done),
        .result (ar_result)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == IW'(MAX_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (req_type == REQ_FREE)
                    begin
                        state_next = S_SUB;
                    end
                    else if (list_empty)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_SUB:
            begin
                // below base or far beyond the region: no divide needed
                if (!wide_sum[ADDR_W] || (wide_sum[ADDR_W-1:OFS_W] != '0))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (ar_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_MUL:
            begin
                if (ar_done)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        base_next       = base_reg;
        size_next       = size_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        clr_cnt_next    = clr_cnt_reg;
        addr_next       = addr_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_addr_next   = out_addr_reg;
        ram_we          = 1'b0;
        ram_waddr       = clr_cnt_reg;
        ram_wdata       = LW'(clr_cnt_reg) + LW'(1);
        ram_re          = 1'b0;
        ram_raddr       = head_reg[IW-1:0];
        ar_req.start    = 1'b0;
        ar_req.op       = AR_MUL;
        ar_opa          = head_wide;
        wide_a          = addr_reg;
        wide_b          = base_reg;
        wide_sub        = 1'b1;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BASE:  base_next  = cfg_data;
                CFG_SIZE:  size_next  = cfg_data[SIZE_W-1:0];
                CFG_COUNT: count_next = cfg_data[COUNT_W-1:0];
                default:   ;
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // entry i links to i+1
                ram_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + IW'(1);
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    addr_next = free_addr;
                    if (req_type == REQ_ALLOC)
                    begin
                        if (list_empty)
                        begin
                            res_status_next = ST_FULL;
                            res_index_next  = '0;
                            res_addr_next   = '0;
                        end
                        else
                        begin
                            // fetch the successor while the offset is built
                            ram_re       = 1'b1;
                            ar_req.start = 1'b1;
                            ar_req.op    = AR_MUL;
                            ar_opa       = head_wide;
                        end
                    end
                end
            end
            S_SUB:
            begin
                wide_a   = addr_reg;
                wide_b   = base_reg;
                wide_sub = 1'b1;
                if (!wide_sum[ADDR_W] || (wide_sum[ADDR_W-1:OFS_W] != '0))
                begin
                    res_status_next = ST_RANGE;
                    res_index_next  = '0;
                    res_addr_next   = '0;
                end
                else
                begin
                    ar_req.start = 1'b1;
                    ar_req.op    = AR_DIV;
                    ar_opa       = wide_sum[OFS_W-1:0];
                end
            end
            S_DIV:
            begin
                if (ar_done)
                begin
                    if (ar_result >= OFS_W'(cap))
                    begin
                        res_status_next = ST_RANGE;
                        res_index_next  = '0;
                        res_addr_next   = '0;
                    end
                    else
                    begin
                        // push the freed slot on the head
                        ram_we          = 1'b1;
                        ram_waddr       = ar_result[IW-1:0];
                        ram_wdata       = head_reg;
                        head_next       = LW'(ar_result);
                        res_status_next = ST_OK;
                        res_index_next  = ar_result[INDEX_W-1:0];
                        res_addr_next   = '0;
                    end
                end
            end
            S_MUL:
            begin
            end
            S_ADD:
            begin
                // slot address is base plus index times stride, wrapping
                wide_a          = base_reg;
                wide_b          = ADDR_W'(ar_result);
                wide_sub        = 1'b0;
                res_status_next = ST_OK;
                res_index_next  = head_wide[INDEX_W-1:0];
                res_addr_next   = wide_sum[ADDR_W-1:0];
                head_next       = ram_rdata;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = res_index_reg;
                    out_addr_next   = res_addr_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            base_reg      <= '0;
            size_reg      <= SIZE_RST;
            count_reg     <= COUNT_RST;
            head_reg      <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            size_reg      <= size_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_addr_reg   <= out_addr_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign slot_index = out_index_reg;
    assign slot_addr  = out_addr_reg;

endmodule

// ----- rtl/dsfl_checker.sv -----
module dsfl_protocol_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [dsfl_pkg::STATUS_W-1:0]   status,
    input  logic [dsfl_pkg::INDEX_W-1:0]    slot_index,
    input  logic [dsfl_pkg::ADDR_W-1:0]     slot_addr
);

    import dsfl_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(status) && $stable(slot_index) && $stable(slot_addr))
        else $error("result changed while stalled");

    // rejected requests carry no slot
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (slot_index == '0) && (slot_addr == '0))
        else $error("rejected request reports a slot");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

    // status codes stay in the defined set
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_FULL) || (status == ST_RANGE))
        else $error("undefined status code");

endmodule

bind descriptor_slot_free_list_top dsfl_protocol_checker u_dsfl_protocol_checker (.*);

// ----- test/dsfl_checker.sv -----
`timescale 1ns / 100ps

module dsfl_checker #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            req_type,
    input  logic [dsfl_pkg::ADDR_W-1:0]     free_addr,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [dsfl_pkg::STATUS_W-1:0]   status,
    input  logic [dsfl_pkg::INDEX_W-1:0]    slot_index,
    input  logic [dsfl_pkg::ADDR_W-1:0]     slot_addr,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [dsfl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dsfl_pkg::ADDR_W-1:0]     cfg_data,
    output int                              mismatches,
    output int                              outstanding
);
    import dsfl_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
        logic [ADDR_W-1:0]   addr;
    } slot_result_t;

    // shadow of the region registers and the free list
    logic [ADDR_W-1:0]  base_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] link_tbl [MAX_SLOTS];
    logic [COUNT_W-1:0] head;

    slot_result_t       expected_q [$];
    slot_result_t       want;

    function automatic logic free_below_base(input logic [ADDR_W-1:0] addr);
        return addr < base_reg;
    endfunction

    function automatic slot_result_t serve_request(input logic kind,
                                                   input logic [ADDR_W-1:0] addr);
        slot_result_t      r;
        int unsigned       cap;
        logic [ADDR_W-1:0] stride;
        logic [ADDR_W-1:0] quot;
        r.status = ST_OK;
        r.index  = '0;
        r.addr   = '0;
        cap      = (count_reg < MAX_SLOTS) ? count_reg : MAX_SLOTS;
        stride   = (size_reg == '0) ? 64'd1 : 64'(size_reg);
        if (kind == REQ_ALLOC)
        begin
            if (head >= cap)
                r.status = ST_FULL;
            else
            begin
                r.index = head[INDEX_W-1:0];
                r.addr  = base_reg + 64'(head) * stride;
                head    = link_tbl[head];
            end
        end
        else if (free_below_base(addr))
            r.status = ST_RANGE;
        else
        begin
            quot = (addr - base_reg) / stride;
            if (quot >= cap)
                r.status = ST_RANGE;
            else
            begin
                // pushed on the head, double frees included
                link_tbl[quot] = head;
                head           = quot[COUNT_W-1:0];
                r.index        = quot[INDEX_W-1:0];
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  = '0;
            size_reg  = SIZE_RST;
            count_reg = COUNT_RST;
            for (int i = 0; i < MAX_SLOTS; i++)
                link_tbl[i] = COUNT_W'(i + 1);
            head = '0;
            expected_q.delete();
            outstanding = 0;
            mismatches  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BASE:  base_reg  = cfg_data;
                    CFG_SIZE:  size_reg  = cfg_data[SIZE_W-1:0];
                    CFG_COUNT: count_reg = cfg_data[COUNT_W-1:0];
                    default:   ;
                endcase
            end
            // results leave before this edge's request is predicted
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result: status %0d slot_index %0d slot_addr %h",
                           status, slot_index, slot_addr);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        mismatches++;
                    end
                    if (slot_index !== want.index)
                    begin
                        $error("slot_index: expected %0d, actual %0d", want.index, slot_index);
                        mismatches++;
                    end
                    if (slot_addr !== want.addr)
                    begin
                        $error("slot_addr: expected %h, actual %h", want.addr, slot_addr);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(serve_request(req_type, free_addr));
            outstanding = expected_q.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import dsfl_pkg::*;

    localparam int MAX_SLOTS    = 1024;
    localparam int PHASES       = 10;
    localparam int PHASE_REQS   = 150;
    localparam int DRAIN_CYCLES = 40;

    // index 3 maps to no register; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic                  req_type   = REQ_ALLOC;
    logic [ADDR_W-1:0]     free_addr  = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [INDEX_W-1:0]    slot_index;
    logic [ADDR_W-1:0]     slot_addr;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = CFG_BASE;
    logic [ADDR_W-1:0]     cfg_data   = '0;

    int mismatches;
    int outstanding;

    // no idling on either side while set
    bit quiet         = 1'b0;
    int stall_left    = 0;
    int reqs_sent     = 0;
    int settings_used = 0;

    // copy of the region registers, used to aim free requests at real slots
    logic [ADDR_W-1:0]  region_base  = '0;
    logic [SIZE_W-1:0]  region_size  = SIZE_RST;
    logic [COUNT_W-1:0] region_count = COUNT_RST;

    always #5 clk = ~clk;

    descriptor_slot_free_list_top #(
        .MAX_SLOTS (MAX_SLOTS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .free_addr  (free_addr),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .slot_index (slot_index),
        .slot_addr  (slot_addr),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    dsfl_checker #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .free_addr   (free_addr),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .slot_index  (slot_index),
        .slot_addr   (slot_addr),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // result side back-pressure: out_ready is held low for short random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= (stall_left == 1);
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(1, 4);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // one register write; cfg_valid is left high so writes can follow back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // all three region registers; bits above each register's width are random
    task automatic set_region(input logic [ADDR_W-1:0]  base,
                              input logic [SIZE_W-1:0]  size,
                              input logic [COUNT_W-1:0] count);
        logic [ADDR_W-1:0] junk;
        junk = {$urandom, $urandom};
        write_reg(CFG_BASE, base);
        write_reg(CFG_SIZE, {junk[ADDR_W-1:SIZE_W], size});
        junk = {$urandom, $urandom};
        write_reg(CFG_COUNT, {junk[ADDR_W-1:COUNT_W], count});
        cfg_valid    <= 1'b0;
        region_base  = base;
        region_size  = size;
        region_count = count;
        settings_used++;
    endtask

    // optional random gap with in_valid low, then hold the request until it is taken
    task automatic send_req(input logic kind, input logic [ADDR_W-1:0] addr);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= kind;
        free_addr <= addr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        reqs_sent++;
    endtask

    // every request answered: the block is idle and registers may change
    task automatic wait_idle;
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned       cap;
        int unsigned       stride;
        int                alloc_pct;
        int                pick;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] noise;
        logic [ADDR_W-1:0] rbase;
        logic [SIZE_W-1:0] rsize;
        logic [COUNT_W-1:0] rcount;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part ---
        // registers are taken during the clearing pass; count only here at first
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        set_region(64'h1000, 13'd16, 11'd8);

        // eight 16-byte slots: drain the list, then one allocate finds it empty
        // (allocate must ignore whatever sits on free_addr)
        repeat (9) send_req(REQ_ALLOC, {$urandom, $urandom});
        send_req(REQ_FREE, 64'h0FFF);          // one byte below base
        send_req(REQ_FREE, 64'h1080);          // index equal to capacity
        send_req(REQ_FREE, '1);                // top of the address space
        send_req(REQ_FREE, 64'h103F);          // last byte of slot 3, truncates to 3
        send_req(REQ_FREE, 64'h1030);          // slot 3 again, double free goes through
        repeat (2) send_req(REQ_ALLOC, '0);    // so slot 3 is handed out twice
        send_req(REQ_FREE, 64'h1000);
        wait_idle;

        // zero stride acts as one byte, region right under the top of memory
        set_region(64'hFFFF_FFFF_FFFF_FFF8, 13'd0, 11'd8);
        send_req(REQ_FREE, 64'hFFFF_FFFF_FFFF_FFFA);
        send_req(REQ_ALLOC, '1);
        wait_idle;

        // zero slots: nothing to hand out, nothing to take back
        set_region(64'hFFFF_FFFF_FFFF_F000, 13'd8191, 11'd0);
        send_req(REQ_ALLOC, '0);
        send_req(REQ_FREE, 64'hFFFF_FFFF_FFFF_F000);
        wait_idle;

        // count above MAX_SLOTS clamps; widest stride makes addresses wrap
        set_region(64'hFFFF_FFFF_FFFF_F000, 13'd8191, 11'd2047);
        repeat (2) send_req(REQ_ALLOC, '0);
        wait_idle;

        // --- random part: one register setting per phase ---
        for (int ph = 0; ph < PHASES; ph++)
        begin
            quiet = (ph == PHASES - 1);
            rbase  = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom}
                                                 : 64'($urandom_range(0, 1 << 20));
            rsize  = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom)
                                                 : SIZE_W'($urandom_range(1, 64));
            rcount = ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom_range(17, 1024))
                                                 : COUNT_W'($urandom_range(1, 16));
            case (ph)
                0:       set_region(64'd0, 13'd1, 11'd1);
                1:       set_region('1, 13'd4096, 11'd1024);
                2:       set_region(rbase, 13'd0, 11'd0);
                3:       set_region(rbase, 13'd8191, 11'd2047);
                default: set_region(rbase, rsize, rcount);
            endcase
            cap       = (region_count < MAX_SLOTS) ? region_count : MAX_SLOTS;
            stride    = (region_size == '0) ? 1 : region_size;
            alloc_pct = $urandom_range(30, 70);

            for (int n = 0; n < PHASE_REQS; n++)
            begin
                noise = {$urandom, $urandom};
                if ($urandom_range(0, 99) < alloc_pct)
                    send_req(REQ_ALLOC, noise);
                else
                begin
                    // mostly slots of the region, some off their first byte,
                    // the rest below base, past the end, or anywhere at all
                    pick = $urandom_range(0, 9);
                    if (pick < 7 && cap != 0)
                        addr = region_base + 64'($urandom_range(0, cap - 1)) * 64'(stride)
                               + ((pick < 5) ? 64'd0 : 64'($urandom_range(0, stride - 1)));
                    else if (pick == 7)
                        addr = region_base - 64'($urandom_range(1, 16));
                    else if (pick == 8)
                        addr = region_base + 64'(cap) * 64'(stride)
                               + 64'($urandom_range(0, stride));
                    else
                        addr = noise;
                    send_req(REQ_FREE, addr);
                end
            end
            wait_idle;
        end

        // let anything stray show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests under %0d register settings", reqs_sent, settings_used);
        $display("regions: empty, single slot, clamped count, zero and widest stride, wrapping");
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
